[hdl/gcf_pkg.sv]
// Gripper command framer package: command codes, frame byte constants,
// the job descriptor passed from front to back, and queue status.
// No dependencies.
package gcf_pkg;

  localparam int MAX_PAYLOAD_DEF = 58;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input command codes
  localparam logic [1:0] CMD_CTRL = 2'd0;
  localparam logic [1:0] CMD_STAT = 2'd1;
  localparam logic [1:0] CMD_RAW  = 2'd2;

  // Frame bytes
  localparam logic [7:0] HDR0  = 8'h55;
  localparam logic [7:0] HDR1  = 8'hAA;
  localparam logic [7:0] TAIL0 = 8'hEB;
  localparam logic [7:0] TAIL1 = 8'hAA;
  localparam logic [7:0] PAY_PREFIX = 8'h02;
  localparam logic [7:0] PAY_CTRL   = 8'h01;
  localparam logic [7:0] PAY_STAT   = 8'h02;

  localparam logic [5:0] CTRL_LEN = 6'd8;
  localparam logic [5:0] STAT_LEN = 6'd2;

  // Checksum seeds: 55 + AA + length + fixed payload bytes, mod 256
  localparam logic [7:0] CTRL_SUM_SEED = 8'h0A;
  localparam logic [7:0] STAT_SUM      = 8'h05;
  localparam logic [7:0] HDR_SUM       = 8'hFF;

  // Clamp limits
  localparam logic [7:0] PCT_MAX = 8'd100;
  localparam logic [7:0] VEL_MIN = 8'd1;
  localparam logic [7:0] EFF_MIN = 8'd20;
  localparam logic [9:0] POS_SCALE = 10'd10;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_CTRL,
    JOB_STAT,
    JOB_RAW
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       hdr;       // raw: emit header before the byte
    logic       close;     // raw: emit checksum and tail after the byte
    logic [5:0] len_byte;  // length byte shown in the header
    logic [7:0] data;      // raw payload byte
    logic [6:0] vel;
    logic [6:0] eff;
    logic [9:0] pos10;
    logic [7:0] sum;       // final checksum for frames that close here
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/gcf_front.sv]
// Front end of the gripper command framer: accepts commands, clamps fields,
// tracks the open raw frame and builds one job per command.
// Depends on gcf_pkg.
module gcf_front #(
  parameter int MAX_PAYLOAD = gcf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_command,
  input  logic [7:0]     in_position_pct,
  input  logic [7:0]     in_velocity_pct,
  input  logic [7:0]     in_effort_pct,
  input  logic [7:0]     in_raw_byte,
  input  logic [5:0]     in_payload_length,
  input  gcf_pkg::q_stat_t q_stat,
  output logic           push_valid,
  output gcf_pkg::job_t  push_job
);
  import gcf_pkg::*;

  logic       open_r, open_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic [7:0] vel_c, eff_c, pos_c;
  logic [9:0] pos10;
  logic [7:0] raw_base, raw_sum;
  logic [5:0] rem_base, rem_dec;
  logic       len_bad;
  logic       accept;

  assign in_ready   = !q_stat.full;
  assign push_valid = in_valid;
  assign accept     = in_valid && in_ready;

  always_comb begin
    vel_c = (in_velocity_pct < VEL_MIN) ? VEL_MIN :
            (in_velocity_pct > PCT_MAX) ? PCT_MAX : in_velocity_pct;
    eff_c = (in_effort_pct < EFF_MIN) ? EFF_MIN :
            (in_effort_pct > PCT_MAX) ? PCT_MAX : in_effort_pct;
    pos_c = (in_position_pct > PCT_MAX) ? PCT_MAX : in_position_pct;
    pos10 = 10'(pos_c) * POS_SCALE;

    len_bad  = (in_payload_length == 6'd0) ||
               (8'(in_payload_length) > 8'(MAX_PAYLOAD));
    raw_base = open_r ? sum_r : (HDR_SUM + 8'(in_payload_length));
    raw_sum  = raw_base + in_raw_byte;
    rem_base = open_r ? rem_r : in_payload_length;
    rem_dec  = rem_base - 6'd1;

    push_job          = '0;
    push_job.kind     = JOB_ERR;
    open_nxt          = open_r;
    rem_nxt           = rem_r;
    sum_nxt           = sum_r;

    unique case (in_command)
      CMD_CTRL: begin
        if (!open_r) begin
          push_job.kind     = JOB_CTRL;
          push_job.hdr      = 1'b1;
          push_job.close    = 1'b1;
          push_job.len_byte = CTRL_LEN;
          push_job.vel      = vel_c[6:0];
          push_job.eff      = eff_c[6:0];
          push_job.pos10    = pos10;
          push_job.sum      = CTRL_SUM_SEED + vel_c + eff_c
                              + 8'(pos10[9:8]) + pos10[7:0];
        end
      end
      CMD_STAT: begin
        if (!open_r) begin
          push_job.kind     = JOB_STAT;
          push_job.hdr      = 1'b1;
          push_job.close    = 1'b1;
          push_job.len_byte = STAT_LEN;
          push_job.sum      = STAT_SUM;
        end
      end
      CMD_RAW: begin
        if (open_r || !len_bad) begin
          push_job.kind     = JOB_RAW;
          push_job.hdr      = !open_r;
          push_job.close    = (rem_dec == 6'd0);
          push_job.len_byte = in_payload_length;
          push_job.data     = in_raw_byte;
          push_job.sum      = raw_sum;
          open_nxt          = (rem_dec != 6'd0);
          rem_nxt           = rem_dec;
          sum_nxt           = (rem_dec == 6'd0) ? 8'd0 : raw_sum;
        end
      end
      default: begin
        // undefined command: error job, state untouched
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= '0;
      sum_r  <= '0;
    end else if (accept) begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

[hdl/gcf_queue.sv]
// Job queue between front and back of the gripper command framer.
// Depends on gcf_pkg.
module gcf_queue #(
  parameter int DEPTH = gcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  gcf_pkg::job_t    push_job,
  input  logic             pop,
  output gcf_pkg::job_t    head_job,
  output gcf_pkg::q_stat_t q_stat
);
  import gcf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hdl/gcf_back.sv]
// Back end of the gripper command framer: walks the head job byte by byte
// into the output register.
// Depends on gcf_pkg.
module gcf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gcf_pkg::job_t    head_job,
  input  gcf_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_rejected
);
  import gcf_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       end_r, end_nxt;
  logic       rej_r, rej_nxt;

  logic [3:0] start, pos, last_pos, body_len, tail_idx;
  logic [2:0] pay_idx;
  logic [7:0] pay_byte, sel_byte;
  logic       is_last, advance, fire;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;
  assign out_rejected  = rej_r;

  assign advance = !valid_r || out_ready;
  assign fire    = advance && !q_stat.empty;
  assign pop     = fire && is_last;

  always_comb begin
    case (head_job.kind)
      JOB_CTRL: body_len = 4'(CTRL_LEN);
      JOB_STAT: body_len = 4'(STAT_LEN);
      default:  body_len = 4'd1;
    endcase

    // Raw bytes skip the header or the trailer unless they open or close.
    start    = (head_job.kind == JOB_RAW && !head_job.hdr) ? 4'd3 : 4'd0;
    pos      = start + step_r;
    if (head_job.kind == JOB_ERR) begin
      last_pos = 4'd0;
    end else if (head_job.kind == JOB_RAW && !head_job.close) begin
      last_pos = 4'd3;
    end else begin
      last_pos = body_len + 4'd5;
    end
    is_last  = (pos == last_pos);

    pay_idx  = 3'(pos - 4'd3);
    tail_idx = pos - 4'd3 - body_len;

    case (head_job.kind)
      JOB_CTRL: begin
        case (pay_idx)
          3'd0:    pay_byte = PAY_PREFIX;
          3'd1:    pay_byte = PAY_CTRL;
          3'd3:    pay_byte = 8'(head_job.vel);
          3'd5:    pay_byte = 8'(head_job.eff);
          3'd6:    pay_byte = 8'(head_job.pos10[9:8]);
          3'd7:    pay_byte = head_job.pos10[7:0];
          default: pay_byte = 8'd0;
        endcase
      end
      JOB_STAT: pay_byte = (pay_idx == 3'd0) ? PAY_PREFIX : PAY_STAT;
      default:  pay_byte = head_job.data;
    endcase

    if (pos == 4'd0) begin
      sel_byte = HDR0;
    end else if (pos == 4'd1) begin
      sel_byte = HDR1;
    end else if (pos == 4'd2) begin
      sel_byte = 8'(head_job.len_byte);
    end else if (pos < body_len + 4'd3) begin
      sel_byte = pay_byte;
    end else if (tail_idx == 4'd0) begin
      sel_byte = head_job.sum;
    end else if (tail_idx == 4'd1) begin
      sel_byte = TAIL0;
    end else begin
      sel_byte = TAIL1;
    end

    step_nxt  = step_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    rej_nxt   = rej_r;
    if (fire) begin
      valid_nxt = 1'b1;
      step_nxt  = is_last ? 4'd0 : step_r + 4'd1;
      if (head_job.kind == JOB_ERR) begin
        byte_nxt = 8'd0;
        end_nxt  = 1'b1;
        rej_nxt  = 1'b1;
      end else begin
        byte_nxt = sel_byte;
        end_nxt  = is_last && head_job.close;
        rej_nxt  = 1'b0;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    rej_r  <= rej_nxt;
  end

endmodule

[hdl/gripper_command_framer.sv]
// Gripper command framer top level: front end, job queue, back end.
// Depends on gcf_pkg, gcf_front, gcf_queue, gcf_back.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------
//  input     in_valid / in_ready   in_command, in_position_pct,
//                                  in_velocity_pct, in_effort_pct,
//                                  in_raw_byte, in_payload_length
//  output    out_valid / out_ready out_byte, out_frame_end, out_rejected
//
// The front end takes one command per cycle while the job queue has room
// (QUEUE_DEPTH entries); the back end sends one byte per cycle unless stalled.
// Bytes per command: control 14, status 8, error 1, raw byte 1, plus 3 when
// it opens a frame and 3 more when it closes one. The back end's byte rate
// sets the sustained command rate; the queue absorbs the header and tail.
// A command's first byte passes through a queue slot, then the output register.
// rst_n is synchronous, active low, and clears the raw frame state, queue
// pointers and count, back end step and output valid. A stalled output holds
// the back end, then fills the queue, then drops in_ready.
module gripper_command_framer #(
  parameter int MAX_PAYLOAD = gcf_pkg::MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = gcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_position_pct,
  input  logic [7:0] in_velocity_pct,
  input  logic [7:0] in_effort_pct,
  input  logic [7:0] in_raw_byte,
  input  logic [5:0] in_payload_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_rejected
);
  import gcf_pkg::*;

  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    push_valid;
  logic    pop;

  // Classify commands and build jobs; tracks the open raw frame.
  gcf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_position_pct  (in_position_pct),
    .in_velocity_pct  (in_velocity_pct),
    .in_effort_pct    (in_effort_pct),
    .in_raw_byte      (in_raw_byte),
    .in_payload_length(in_payload_length),
    .q_stat           (q_stat),
    .push_valid       (push_valid),
    .push_job         (push_job)
  );

  // Decouple command acceptance from byte output.
  gcf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .q_stat    (q_stat)
  );

  // Serialize the head job into link bytes.
  gcf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .out_rejected (out_rejected)
  );

`ifndef SYNTHESIS
  // An error transaction is a single zero byte that also ends its group.
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_frame_end && (out_byte == 8'd0))
    else $error("rejected result is not a terminated zero byte");

  // Every good frame ends on the second tail byte.
  a_frame_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && !out_rejected |-> out_byte == TAIL1)
    else $error("frame ended on a byte other than the tail");

  // Queue status is never full and empty at once.
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Input backpressure only comes from a full queue, so a stalled input never sees an empty queue.
  a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> !q_stat.empty)
    else $error("input stalled with an empty queue");
`endif

endmodule
